>>> hw/rtl/phm_pkg.sv
// Shared constants and helpers for the peak-hold meter controller.
`default_nettype none

package phm_pkg;

    // Input operation codes
    localparam logic [2:0] OP_SAMPLE  = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_BUTTON  = 3'd2;
    localparam logic [2:0] OP_BATTERY = 3'd3;
    localparam logic [2:0] OP_RANGE   = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_VALUE   = 2'd0;
    localparam logic [1:0] KIND_OVER    = 2'd1;
    localparam logic [1:0] KIND_VERSION = 2'd2;

    // Range selections (decimal digit position)
    localparam logic [1:0] RANGE_NONE  = 2'd0;
    localparam logic [1:0] RANGE_ONE   = 2'd1;
    localparam logic [1:0] RANGE_TWO   = 2'd2;
    localparam logic [1:0] RANGE_THREE = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_GAIN      = 3'd0;
    localparam logic [2:0] REG_OVER_LIM  = 3'd1;
    localparam logic [2:0] REG_OVER_CODE = 3'd2;
    localparam logic [2:0] REG_BATT_THR  = 3'd3;
    localparam logic [2:0] REG_DISCHARGE = 3'd4;
    localparam logic [2:0] REG_SETTLE    = 3'd5;
    localparam logic [2:0] REG_HOLD      = 3'd6;
    localparam logic [2:0] REG_VERSION   = 3'd7;

    // Register reset values
    localparam logic [15:0] GAIN_RST      = 16'd4097;
    localparam int          OVER_LIM_RST  = 2000;
    localparam int          OVER_CODE_RST = 200000;
    localparam logic [15:0] BATT_THR_RST  = 16'd35000;
    localparam logic [7:0]  DISCHARGE_RST = 8'd6;
    localparam logic [7:0]  SETTLE_RST    = 8'd4;
    localparam logic [7:0]  HOLD_RST      = 8'd32;
    localparam logic [7:0]  VERSION_RST   = 8'd17;

    // Auto-zero offset store
    localparam int OFFSET_BITS = 13;
    localparam int OFF_MIN     = -4096;
    localparam int OFF_MAX     = 4095;

    // Saturating 8-bit counter step
    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/phm_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
`default_nettype none

interface phm_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/phm_fifo.sv
// Four-entry result queue taking up to two beats per cycle, releasing one.
`default_nettype none

module phm_fifo #(
    parameter type entry_t = logic
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] push_cnt,
    input  entry_t          push_a,
    input  entry_t          push_b,
    input  wire logic       pop,
    output logic            out_valid,
    output entry_t          out_data,
    output logic [2:0]      level
);

    entry_t      entries_reg [4];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  wr_ptr_next;
    logic [1:0]  rd_ptr_reg;
    logic [1:0]  rd_ptr_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic        do_pop;

    assign do_pop    = pop && (count_reg != 3'd0);
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = entries_reg[rd_ptr_reg];
    assign level     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, do_pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'b00, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2)
        begin
            entries_reg[wr_ptr_reg + 2'd1] <= push_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/peak_hold_meter_autozero.sv
// Top level of the peak-hold field meter controller with auto-zero.
//
//  channel   | direction | beat carries
//  ----------+-----------+------------------------------------------------
//  items     | in        | operation, adc_value, button_held, range_pins
//  results   | out       | kind, shown_value, range_digit, low_battery,
//            |           | analog_short, last_result
//  cfg_*     | in        | write enable, register index, write data
//
// One item enters per cycle while stage two advances. Stage one registers the
// item with the centred, gain-scaled sample (the one multiplier) and the
// battery compare; stage two updates all meter state and pushes zero, one or
// two result beats into a four-entry queue whose head drives the output. Stage
// two advances while the queue holds two or fewer beats, so single-result items
// stream at one per cycle while the output is taken. Reset (rst_n low) restores
// the configuration registers and meter state to their defaults and leaves the
// meter in its reset sequence with the short closed.
`default_nettype none

module peak_hold_meter_autozero #(
    parameter int SAMPLE_BITS = 16,
    parameter int VALUE_BITS  = 18,
    localparam int CFG_W = (VALUE_BITS > 16) ? VALUE_BITS : 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    phm_stream_if.sink            items,
    phm_stream_if.source          results,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int VB  = VALUE_BITS;
    localparam int PW  = SB + 17;                       // product width
    localparam int CW0 = (SB + 2 > VB + 2) ? SB + 2 : VB + 2;
    localparam int CW  = (CW0 > 14) ? CW0 : 14;         // compare width
    localparam int BW  = (SB > 16) ? SB : 16;           // battery compare width
    localparam int OB  = phm_pkg::OFFSET_BITS;

    localparam logic signed [CW-1:0] OFF_MIN_W = CW'(phm_pkg::OFF_MIN);
    localparam logic signed [CW-1:0] OFF_MAX_W = CW'(phm_pkg::OFF_MAX);

    typedef struct packed {
        logic [1:0]    kind;
        logic [VB-1:0] shown_value;
        logic [1:0]    range_digit;
        logic          low_battery;
        logic          analog_short;
        logic          last_result;
    } result_t;

    // ---------------------------------------------------------------- config
    logic [15:0]   gain_reg;
    logic [VB-1:0] over_limit_reg;
    logic [VB-1:0] over_code_reg;
    logic [15:0]   batt_thr_reg;
    logic [7:0]    discharge_ticks_reg;
    logic [7:0]    settle_ticks_reg;
    logic [7:0]    hold_ticks_reg;
    logic [7:0]    version_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg            <= phm_pkg::GAIN_RST;
            over_limit_reg      <= VB'(phm_pkg::OVER_LIM_RST);
            over_code_reg       <= VB'(phm_pkg::OVER_CODE_RST);
            batt_thr_reg        <= phm_pkg::BATT_THR_RST;
            discharge_ticks_reg <= phm_pkg::DISCHARGE_RST;
            settle_ticks_reg    <= phm_pkg::SETTLE_RST;
            hold_ticks_reg      <= phm_pkg::HOLD_RST;
            version_reg         <= phm_pkg::VERSION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                phm_pkg::REG_GAIN:      gain_reg            <= cfg_data[15:0];
                phm_pkg::REG_OVER_LIM:  over_limit_reg      <= cfg_data[VB-1:0];
                phm_pkg::REG_OVER_CODE: over_code_reg       <= cfg_data[VB-1:0];
                phm_pkg::REG_BATT_THR:  batt_thr_reg        <= cfg_data[15:0];
                phm_pkg::REG_DISCHARGE: discharge_ticks_reg <= cfg_data[7:0];
                phm_pkg::REG_SETTLE:    settle_ticks_reg    <= cfg_data[7:0];
                phm_pkg::REG_HOLD:      hold_ticks_reg      <= cfg_data[7:0];
                phm_pkg::REG_VERSION:   version_reg         <= cfg_data[7:0];
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------------ stage one
    // Centre the sample, scale by the Q16 gain and truncate toward zero.
    logic signed [SB-1:0] centred;
    logic signed [16:0]   gain_s;
    logic signed [PW-1:0] product;
    logic signed [PW-1:0] product_adj;
    logic signed [SB-1:0] scaled;
    logic                 batt_low_flag;

    assign centred     = {~items.data.adc_value[SB-1], items.data.adc_value[SB-2:0]};
    assign gain_s      = {1'b0, gain_reg};
    assign product     = centred * gain_s;
    assign product_adj = product + (product[PW-1] ? PW'(17'h0FFFF) : PW'(0));
    assign scaled      = product_adj[SB+15:16];
    assign batt_low_flag = (BW'(items.data.adc_value) <= BW'(batt_thr_reg));

    logic                 s1_valid_reg;
    logic [2:0]           s1_op_reg;
    logic                 s1_button_reg;
    logic [2:0]           s1_pins_reg;
    logic signed [SB-1:0] s1_scaled_reg;
    logic                 s1_batt_low_reg;

    logic       go;
    logic [2:0] q_level;
    logic       take;

    // Stage two advances while the queue has room for two beats.
    assign go          = s1_valid_reg && (q_level <= 3'd2);
    assign items.ready = !s1_valid_reg || go;
    assign take        = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            s1_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_op_reg       <= items.data.operation;
            s1_button_reg   <= items.data.button_held;
            s1_pins_reg     <= items.data.range_pins;
            s1_scaled_reg   <= scaled;
            s1_batt_low_reg <= batt_low_flag;
        end
    end

    // ------------------------------------------------------------ meter state
    logic [VB-1:0]          held_reg,        held_next;
    logic signed [OB-1:0]   offset_reg,      offset_next;
    logic [1:0]             range_reg,       range_next;
    logic                   in_reset_reg,    in_reset_next;
    logic                   settling_reg,    settling_next;
    logic                   hold_watch_reg,  hold_watch_next;
    logic [7:0]             hold_count_reg,  hold_count_next;
    logic [7:0]             dis_count_reg,   dis_count_next;
    logic [7:0]             set_count_reg,   set_count_next;
    logic                   batt_low_reg,    batt_low_next;
    logic                   refresh_reg,     refresh_next;
    logic                   short_reg,       short_next;

    // ------------------------------------------------------------ stage two
    logic signed [CW-1:0] s_ext;
    logic signed [CW-1:0] m_val;
    logic signed [CW-1:0] off_clamped;
    logic signed [CW-1:0] limit_ext;
    logic signed [CW-1:0] held_ext;

    logic    ver_emit;
    logic    val_emit;
    logic    rst_emit;
    result_t ver_res;
    result_t val_res;
    result_t rst_res;
    result_t slot_a;
    result_t slot_b;
    logic [1:0] push_cnt;
    logic [1:0] want;

    assign s_ext     = CW'(s1_scaled_reg);
    assign limit_ext = CW'(over_limit_reg);
    assign held_ext  = CW'(held_reg);

    always_comb
    begin
        held_next       = held_reg;
        offset_next     = offset_reg;
        range_next      = range_reg;
        in_reset_next   = in_reset_reg;
        settling_next   = settling_reg;
        hold_watch_next = hold_watch_reg;
        hold_count_next = hold_count_reg;
        dis_count_next  = dis_count_reg;
        set_count_next  = set_count_reg;
        batt_low_next   = batt_low_reg;
        refresh_next    = refresh_reg;
        short_next      = short_reg;

        ver_emit = 1'b0;
        val_emit = 1'b0;
        rst_emit = 1'b0;
        want     = phm_pkg::RANGE_NONE;

        // Measured reading: scaled minus offset, floored at zero.
        m_val = s_ext - CW'(offset_reg);
        if (m_val < 0)
        begin
            m_val = '0;
        end

        // Offset candidate, saturated to the offset store.
        off_clamped = s_ext;
        if (off_clamped < OFF_MIN_W)
        begin
            off_clamped = OFF_MIN_W;
        end
        if (off_clamped > OFF_MAX_W)
        begin
            off_clamped = OFF_MAX_W;
        end

        // Version beat shows the short as it stands before this tick acts.
        ver_res              = '0;
        ver_res.kind         = phm_pkg::KIND_VERSION;
        ver_res.shown_value  = VB'(version_reg);
        ver_res.range_digit  = phm_pkg::RANGE_ONE;
        ver_res.low_battery  = batt_low_reg;
        ver_res.analog_short = short_reg;

        if (go)
        begin
            case (s1_op_reg)
                phm_pkg::OP_SAMPLE:
                begin
                    // Ignore samples while the reset sequence runs.
                    if (!in_reset_reg)
                    begin
                        if (m_val >= limit_ext)
                        begin
                            m_val        = CW'(over_code_reg);
                            refresh_next = 1'b1;
                        end
                        if (m_val > held_ext)
                        begin
                            held_next    = m_val[VB-1:0];
                            refresh_next = 1'b1;
                        end
                    end
                end
                phm_pkg::OP_TICK:
                begin
                    // Watch for a long button hold.
                    if (hold_watch_reg)
                    begin
                        if (s1_button_reg)
                        begin
                            hold_count_next = phm_pkg::sat_inc(hold_count_reg);
                        end
                        else
                        begin
                            hold_watch_next = 1'b0;
                            hold_count_next = 8'd0;
                        end
                        if (hold_count_next >= hold_ticks_reg)
                        begin
                            ver_emit        = 1'b1;
                            hold_count_next = 8'd0;
                            hold_watch_next = 1'b0;
                            in_reset_next   = 1'b1;
                        end
                    end
                    // Advance the reset sequence: discharge, capture, settle.
                    if (in_reset_next)
                    begin
                        if (dis_count_reg >= discharge_ticks_reg)
                        begin
                            if (!settling_reg)
                            begin
                                offset_next   = off_clamped[OB-1:0];
                                held_next     = '0;
                                short_next    = 1'b0;
                                settling_next = 1'b1;
                            end
                            else if (set_count_reg >= settle_ticks_reg)
                            begin
                                dis_count_next = 8'd0;
                                set_count_next = 8'd0;
                                held_next      = '0;
                                in_reset_next  = 1'b0;
                                settling_next  = 1'b0;
                                refresh_next   = 1'b1;
                            end
                            else
                            begin
                                set_count_next = phm_pkg::sat_inc(set_count_reg);
                            end
                        end
                        else
                        begin
                            dis_count_next = phm_pkg::sat_inc(dis_count_reg);
                        end
                    end
                    if (refresh_next)
                    begin
                        val_emit     = 1'b1;
                        refresh_next = 1'b0;
                    end
                end
                phm_pkg::OP_BUTTON:
                begin
                    if (!in_reset_reg)
                    begin
                        rst_emit        = 1'b1;
                        hold_watch_next = 1'b1;
                        short_next      = 1'b1;
                        in_reset_next   = 1'b1;
                    end
                end
                phm_pkg::OP_BATTERY:
                begin
                    batt_low_next = s1_batt_low_reg;
                    refresh_next  = 1'b1;
                end
                phm_pkg::OP_RANGE:
                begin
                    // Test pins in the order one, three, two.
                    if (s1_pins_reg[2] && (range_reg != phm_pkg::RANGE_ONE))
                    begin
                        want = phm_pkg::RANGE_ONE;
                    end
                    else if (s1_pins_reg[1] && (range_reg != phm_pkg::RANGE_THREE))
                    begin
                        want = phm_pkg::RANGE_THREE;
                    end
                    else if (s1_pins_reg[0] && (range_reg != phm_pkg::RANGE_TWO))
                    begin
                        want = phm_pkg::RANGE_TWO;
                    end
                    if (want != phm_pkg::RANGE_NONE)
                    begin
                        range_next      = want;
                        refresh_next    = 1'b1;
                        held_next       = over_code_reg;
                        rst_emit        = 1'b1;
                        hold_watch_next = 1'b1;
                        short_next      = 1'b1;
                        in_reset_next   = 1'b1;
                    end
                end
                default:
                begin
                    // Drop unused operation codes.
                end
            endcase
        end

        val_res              = '0;
        val_res.kind         = phm_pkg::KIND_VALUE;
        val_res.shown_value  = held_next;
        val_res.range_digit  = range_reg;
        val_res.low_battery  = batt_low_reg;
        val_res.analog_short = short_next;

        rst_res              = '0;
        rst_res.kind         = phm_pkg::KIND_OVER;
        rst_res.shown_value  = over_code_reg;
        rst_res.range_digit  = range_next;
        rst_res.low_battery  = batt_low_reg;
        rst_res.analog_short = 1'b1;

        // Pack the beats in order; mark the final one.
        push_cnt = 2'({1'b0, ver_emit} + {1'b0, val_emit} + {1'b0, rst_emit});
        if (ver_emit)
        begin
            slot_a = ver_res;
        end
        else if (val_emit)
        begin
            slot_a = val_res;
        end
        else
        begin
            slot_a = rst_res;
        end
        slot_b             = val_res;
        slot_a.last_result = (push_cnt == 2'd1);
        slot_b.last_result = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= VB'(phm_pkg::OVER_CODE_RST);
            offset_reg     <= '0;
            range_reg      <= phm_pkg::RANGE_TWO;
            in_reset_reg   <= 1'b1;
            settling_reg   <= 1'b0;
            hold_watch_reg <= 1'b0;
            hold_count_reg <= 8'd0;
            dis_count_reg  <= 8'd0;
            set_count_reg  <= 8'd0;
            batt_low_reg   <= 1'b0;
            refresh_reg    <= 1'b1;
            short_reg      <= 1'b1;
        end
        else
        begin
            held_reg       <= held_next;
            offset_reg     <= offset_next;
            range_reg      <= range_next;
            in_reset_reg   <= in_reset_next;
            settling_reg   <= settling_next;
            hold_watch_reg <= hold_watch_next;
            hold_count_reg <= hold_count_next;
            dis_count_reg  <= dis_count_next;
            set_count_reg  <= set_count_next;
            batt_low_reg   <= batt_low_next;
            refresh_reg    <= refresh_next;
            short_reg      <= short_next;
        end
    end

    // ------------------------------------------------------------ result queue
    result_t q_data;
    logic    q_valid;

    phm_fifo #(
        .entry_t (result_t)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_a    (slot_a),
        .push_b    (slot_b),
        .pop       (results.ready),
        .out_valid (q_valid),
        .out_data  (q_data),
        .level     (q_level)
    );

    assign results.valid = q_valid;
    assign results.data  = q_data;

endmodule

`default_nettype wire

>>> hw/rtl/phm_checker.sv
// Port-level checks on the meter's result channel, bound to the top level.
`default_nettype none

module phm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [1:0] res_kind,
    input wire logic [1:0] res_digit,
    input wire logic       res_short,
    input wire logic       res_last
);

    // A stalled beat stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat withdrawn while stalled");

    // A reset-start beat always shows the short closed.
    a_over_short: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == phm_pkg::KIND_OVER) |-> res_short)
        else $error("over-range beat with short open");

    // Reset-start beats are the only result of their item.
    a_over_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == phm_pkg::KIND_OVER) |-> res_last)
        else $error("over-range beat not marked final");

    // Version beats sit on digit one; a beat never shows an empty range.
    a_digit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_digit != phm_pkg::RANGE_NONE) &&
                      ((res_kind != phm_pkg::KIND_VERSION) ||
                       (res_digit == phm_pkg::RANGE_ONE)))
        else $error("bad range digit on result beat");

endmodule

bind peak_hold_meter_autozero phm_checker u_phm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_kind  (results.data.kind),
    .res_digit (results.data.range_digit),
    .res_short (results.data.analog_short),
    .res_last  (results.data.last_result)
);

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the peak-hold field meter controller with auto-zero.
`timescale 1ns / 100ps

module testbench;
    import phm_pkg::*;

    // Beat layouts of the two channels, in port order
    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] adc_value;
        logic        button_held;
        logic [2:0]  range_pins;
    } meter_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [17:0] shown_value;
        logic [1:0]  range_digit;
        logic        low_battery;
        logic        analog_short;
        logic        last_result;
    } meter_beat_t;

    // Operation codes the block ignores
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Auto-zero offset saturation bounds and the centre of the converter scale
    localparam longint OFFSET_FLOOR = -4096;
    localparam longint OFFSET_CEIL  = 4095;
    localparam longint ADC_CENTRE   = 32768;

    localparam int DRAIN_CYCLES   = 16;   // pipeline plus result queue, with margin
    localparam int WATCHDOG_LIMIT = 2000; // cycles with no beat on either channel
    localparam int LONG_STALL_AT  = 400;  // items accepted before the long hold-off
    localparam int LONG_STALL_LEN = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [17:0] cfg_data;

    phm_stream_if #(.payload_t(meter_item_t)) item_bus ();
    phm_stream_if #(.payload_t(meter_beat_t)) result_bus ();

    peak_hold_meter_autozero dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (item_bus),
        .results   (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Meter predictor: own copy of the registers and of the meter state
    // ------------------------------------------------------------------
    logic [15:0] c_gain;
    logic [17:0] c_over_lim;
    logic [17:0] c_over_code;
    logic [15:0] c_batt;
    logic [7:0]  c_discharge;
    logic [7:0]  c_settle;
    logic [7:0]  c_hold;
    logic [7:0]  c_version;

    logic [17:0] m_held;
    longint      m_offset;
    logic [1:0]  m_range;
    logic        m_in_reset;
    logic        m_settling;
    logic        m_hold_watch;
    logic [7:0]  m_hold_count;
    logic [7:0]  m_discharge;
    logic [7:0]  m_settle;
    logic        m_batt_low;
    logic        m_refresh;
    logic        m_short;

    meter_beat_t expected_beats [$];
    meter_item_t pending_items [$];

    // Run bookkeeping
    int          errors;
    int          beats_checked;
    int          versions_seen;
    int          overs_seen;
    int          settings_run;
    int          items_taken;
    int          quiet_cycles;
    bit          idle_on;
    int unsigned feed_gap;
    int unsigned stall_left;
    bit          long_stall_done;
    meter_beat_t oldest_beat;

    function automatic void reset_meter();
        c_gain       = GAIN_RST;
        c_over_lim   = 18'(OVER_LIM_RST);
        c_over_code  = 18'(OVER_CODE_RST);
        c_batt       = BATT_THR_RST;
        c_discharge  = DISCHARGE_RST;
        c_settle     = SETTLE_RST;
        c_hold       = HOLD_RST;
        c_version    = VERSION_RST;
        m_held       = c_over_code;
        m_offset     = 0;
        m_range      = RANGE_TWO;
        m_in_reset   = 1'b1;
        m_settling   = 1'b0;
        m_hold_watch = 1'b0;
        m_hold_count = 8'd0;
        m_discharge  = 8'd0;
        m_settle     = 8'd0;
        m_batt_low   = 1'b0;
        m_refresh    = 1'b1;
        m_short      = 1'b1;
    endfunction

    function automatic logic [7:0] bump8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // Centre, multiply by the Q16 gain and truncate toward zero
    function automatic longint scaled_reading(input logic [15:0] adc);
        longint prod;
        prod = (longint'(adc) - ADC_CENTRE) * longint'(c_gain);
        if (prod < 0)
            return -((-prod) >>> 16);
        return prod >>> 16;
    endfunction

    // Status segments come from the state at the moment of the beat
    function automatic meter_beat_t make_beat(input logic [1:0] kind, input logic [17:0] value,
                                              input logic [1:0] digit);
        meter_beat_t b;
        b.kind         = kind;
        b.shown_value  = value;
        b.range_digit  = digit;
        b.low_battery  = m_batt_low;
        b.analog_short = m_short;
        b.last_result  = 1'b0;
        return b;
    endfunction

    function automatic meter_beat_t open_reset_sequence();
        m_hold_watch = 1'b1;
        m_short      = 1'b1;
        m_in_reset   = 1'b1;
        return make_beat(KIND_OVER, c_over_code, m_range);
    endfunction

    // Advance the meter by one accepted item and queue the beats it causes
    task automatic advance_meter(input meter_item_t it);
        meter_beat_t got [2];
        int          n;
        longint      level;
        logic [1:0]  want;
        n    = 0;
        want = RANGE_NONE;
        case (it.operation)
            OP_SAMPLE: begin
                if (!m_in_reset) begin
                    level = scaled_reading(it.adc_value) - m_offset;
                    if (level < 0)
                        level = 0;
                    if (level >= longint'(c_over_lim)) begin
                        level     = longint'(c_over_code);
                        m_refresh = 1'b1;
                    end
                    if (level > longint'(m_held)) begin
                        m_held    = level[17:0];
                        m_refresh = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if (m_hold_watch) begin
                    if (it.button_held) begin
                        m_hold_count = bump8(m_hold_count);
                    end
                    else begin
                        m_hold_watch = 1'b0;
                        m_hold_count = 8'd0;
                    end
                    if (m_hold_count >= c_hold) begin
                        got[n] = make_beat(KIND_VERSION, 18'(c_version), RANGE_ONE);
                        n++;
                        m_hold_count = 8'd0;
                        m_hold_watch = 1'b0;
                        m_in_reset   = 1'b1;
                    end
                end
                if (m_in_reset) begin
                    if (m_discharge >= c_discharge) begin
                        if (!m_settling) begin
                            // Capture the zero offset with the short closed
                            level = scaled_reading(it.adc_value);
                            if (level < OFFSET_FLOOR)
                                level = OFFSET_FLOOR;
                            if (level > OFFSET_CEIL)
                                level = OFFSET_CEIL;
                            m_offset   = level;
                            m_held     = 18'd0;
                            m_short    = 1'b0;
                            m_settling = 1'b1;
                        end
                        else if (m_settle >= c_settle) begin
                            m_discharge = 8'd0;
                            m_settle    = 8'd0;
                            m_held      = 18'd0;
                            m_in_reset  = 1'b0;
                            m_settling  = 1'b0;
                            m_refresh   = 1'b1;
                        end
                        else begin
                            m_settle = bump8(m_settle);
                        end
                    end
                    else begin
                        m_discharge = bump8(m_discharge);
                    end
                end
                if (m_refresh) begin
                    got[n] = make_beat(KIND_VALUE, m_held, m_range);
                    n++;
                    m_refresh = 1'b0;
                end
            end
            OP_BUTTON: begin
                if (!m_in_reset) begin
                    got[n] = open_reset_sequence();
                    n++;
                end
            end
            OP_BATTERY: begin
                m_batt_low = (it.adc_value <= c_batt);
                m_refresh  = 1'b1;
            end
            OP_RANGE: begin
                // Pins are tried in the order range one, range three, range two
                if (it.range_pins[2] && m_range != RANGE_ONE)
                    want = RANGE_ONE;
                else if (it.range_pins[1] && m_range != RANGE_THREE)
                    want = RANGE_THREE;
                else if (it.range_pins[0] && m_range != RANGE_TWO)
                    want = RANGE_TWO;
                if (want != RANGE_NONE) begin
                    m_range   = want;
                    m_refresh = 1'b1;
                    m_held    = c_over_code;
                    got[n]    = open_reset_sequence();
                    n++;
                end
            end
            default: ;
        endcase
        if (n > 0)
            got[n - 1].last_result = 1'b1;
        for (int i = 0; i < n; i++)
            expected_beats.push_back(got[i]);
    endtask

    // ------------------------------------------------------------------
    // Item driver: feed beats from the pending queue, with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_bus.valid <= 1'b0;
            item_bus.data  <= '0;
            feed_gap       <= 0;
        end
        else if (!item_bus.valid || item_bus.ready) begin
            if (feed_gap != 0) begin
                item_bus.valid <= 1'b0;
                feed_gap       <= feed_gap - 1;
            end
            else if (pending_items.size() != 0) begin
                item_bus.data  <= pending_items.pop_front();
                item_bus.valid <= 1'b1;
                // Open a gap after this beat now and then
                if (idle_on && $urandom_range(0, 9) == 0)
                    feed_gap <= $urandom_range(1, 16);
            end
            else begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random back-pressure bursts and one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_bus.ready <= 1'b0;
            stall_left       <= 0;
            long_stall_done  <= 1'b0;
        end
        else if (!long_stall_done && items_taken >= LONG_STALL_AT) begin
            // Hold off long enough for the result queue to fill and the input to stall
            result_bus.ready <= 1'b0;
            stall_left       <= LONG_STALL_LEN;
            long_stall_done  <= 1'b1;
        end
        else if (stall_left != 0) begin
            result_bus.ready <= 1'b0;
            stall_left       <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 11) == 0) begin
            result_bus.ready <= 1'b0;
            stall_left       <= $urandom_range(0, 15);
        end
        else begin
            result_bus.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted item, then check every result beat
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            // Predict first, so a beat caused in this cycle is already queued
            if (item_bus.valid && item_bus.ready) begin
                advance_meter(item_bus.data);
                items_taken <= items_taken + 1;
            end
            if (result_bus.valid && result_bus.ready) begin
                beats_checked++;
                if (result_bus.data.kind == KIND_VERSION)
                    versions_seen++;
                if (result_bus.data.kind == KIND_OVER)
                    overs_seen++;
                if (expected_beats.size() == 0) begin
                    $display("%0t: result beat with none expected, expected nothing, got kind %0d value %0d",
                             $time, result_bus.data.kind, result_bus.data.shown_value);
                    errors++;
                end
                else begin
                    oldest_beat = expected_beats.pop_front();
                    check_field("kind", oldest_beat.kind, result_bus.data.kind);
                    check_field("shown_value", oldest_beat.shown_value,
                                result_bus.data.shown_value);
                    check_field("range_digit", oldest_beat.range_digit,
                                result_bus.data.range_digit);
                    check_field("low_battery", oldest_beat.low_battery,
                                result_bus.data.low_battery);
                    check_field("analog_short", oldest_beat.analog_short,
                                result_bus.data.analog_short);
                    check_field("last_result", oldest_beat.last_result,
                                result_bus.data.last_result);
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d beats still expected",
                         $time, quiet_cycles, expected_beats.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic meter_item_t make_item(input logic [2:0] op, input logic [15:0] adc,
                                              input logic btn, input logic [2:0] pins);
        meter_item_t it;
        it.operation   = op;
        it.adc_value   = adc;
        it.button_held = btn;
        it.range_pins  = pins;
        return it;
    endfunction

    // Spread converter codes over the scale, the centre and the top end
    function automatic logic [15:0] random_adc();
        case ($urandom_range(0, 3))
            0:       return 16'(32768 + $urandom_range(0, 2047) - 1024);
            1:       return 16'($urandom_range(60000, 65535));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Write every register while the block is idle, and mirror the values
    task automatic load_settings(input logic [15:0] gain, input logic [17:0] lim,
                                 input logic [17:0] code, input logic [15:0] batt,
                                 input logic [7:0] dis, input logic [7:0] settle,
                                 input logic [7:0] hold, input logic [7:0] ver);
        logic [17:0] vals [8];
        vals[REG_GAIN]      = 18'(gain);
        vals[REG_OVER_LIM]  = lim;
        vals[REG_OVER_CODE] = code;
        vals[REG_BATT_THR]  = 18'(batt);
        vals[REG_DISCHARGE] = 18'(dis);
        vals[REG_SETTLE]    = 18'(settle);
        vals[REG_HOLD]      = 18'(hold);
        vals[REG_VERSION]   = 18'(ver);
        for (int i = 0; i < 8; i++) begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
        end
        @(posedge clk);
        cfg_we      <= 1'b0;
        c_gain      = gain;
        c_over_lim  = lim;
        c_over_code = code;
        c_batt      = batt;
        c_discharge = dis;
        c_settle    = settle;
        c_hold      = hold;
        c_version   = ver;
        settings_run++;
    endtask

    // Hold the sender until every beat is accepted and every result is back,
    // then let the pipeline drain items that give no result
    task automatic wait_quiet();
        @(negedge clk);
        while (pending_items.size() != 0 || item_bus.valid || expected_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Queue one phase of random sequences, mostly well formed
    task automatic queue_phase(input int budget, input bit idling);
        int made;
        int pick;
        int k;
        made = 0;
        @(negedge clk);
        idle_on = idling;
        while (made < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // Run of field samples
                k = $urandom_range(1, 8);
                repeat (k)
                    pending_items.push_back(make_item(OP_SAMPLE, random_adc(),
                                            1'($urandom), 3'($urandom)));
                made += k;
            end
            else if (pick < 60) begin
                // Run of ticks with a random button level
                k = $urandom_range(1, 10);
                repeat (k)
                    pending_items.push_back(make_item(OP_TICK, random_adc(),
                                            1'($urandom), 3'($urandom)));
                made += k;
            end
            else if (pick < 72) begin
                // Start a reset sequence, then hold the button around the hold time
                if ($urandom_range(0, 1) == 0)
                    pending_items.push_back(make_item(OP_BUTTON, 16'($urandom),
                                            1'($urandom), 3'($urandom)));
                else
                    pending_items.push_back(make_item(OP_RANGE, 16'($urandom),
                                            1'($urandom), 3'($urandom)));
                k = int'(c_hold) + $urandom_range(0, 2) - 1;
                if (k > 40 && $urandom_range(0, 3) != 0)
                    k = $urandom_range(1, 40);
                repeat (k)
                    pending_items.push_back(make_item(OP_TICK, random_adc(), 1'b1,
                                            3'($urandom)));
                pending_items.push_back(make_item(OP_TICK, random_adc(), 1'b0, 3'($urandom)));
                made += k + 2;
            end
            else if (pick < 80) begin
                // Enough ticks to run the whole reset sequence to its end, unless capped at 60
                k = int'(c_discharge) + int'(c_settle) + 2;
                if (k > 60 && $urandom_range(0, 3) != 0)
                    k = 60;
                repeat (k)
                    pending_items.push_back(make_item(OP_TICK, random_adc(),
                                            1'($urandom), 3'($urandom)));
                made += k;
            end
            else if (pick < 88) begin
                // Battery sample, often right at the threshold
                if ($urandom_range(0, 1) == 0)
                    pending_items.push_back(make_item(OP_BATTERY,
                                            16'(int'(c_batt) + $urandom_range(0, 2) - 1),
                                            1'($urandom), 3'($urandom)));
                else
                    pending_items.push_back(make_item(OP_BATTERY, 16'($urandom),
                                            1'($urandom), 3'($urandom)));
                made++;
            end
            else if (pick < 96) begin
                pending_items.push_back(make_item(OP_RANGE, 16'($urandom),
                                        1'($urandom), 3'($urandom)));
                made++;
            end
            else begin
                // Spare operation codes: dropped by the block, not counted
                pending_items.push_back(make_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                                        16'($urandom), 1'($urandom), 3'($urandom)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Drive every input to a known value before the first edge
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_GAIN;
        cfg_data         = '0;
        item_bus.valid   = 1'b0;
        item_bus.data    = '0;
        result_bus.ready = 1'b0;
        errors           = 0;
        beats_checked    = 0;
        versions_seen    = 0;
        overs_seen       = 0;
        settings_run     = 0;
        items_taken      = 0;
        quiet_cycles     = 0;
        idle_on          = 1'b1;
        reset_meter();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part: no discharge or settle wait, version after two held ticks
        load_settings(GAIN_RST, 18'(OVER_LIM_RST), 18'(OVER_CODE_RST), BATT_THR_RST,
                      8'd0, 8'd0, 8'd2, VERSION_RST);
        @(negedge clk);
        pending_items.push_back(make_item(OP_SAMPLE, 16'hFFFF, 1'b1, 3'd7)); // dropped in reset
        pending_items.push_back(make_item(OP_RANGE, 16'h0000, 1'b0, 3'd0));  // no pin set
        pending_items.push_back(make_item(OP_RANGE, 16'h0000, 1'b0, 3'd1));  // already range two
        pending_items.push_back(make_item(OP_BATTERY, 16'd35000, 1'b0, 3'd0)); // at threshold
        pending_items.push_back(make_item(OP_BATTERY, 16'd35001, 1'b0, 3'd0));
        pending_items.push_back(make_item(OP_BUTTON, 16'h0000, 1'b1, 3'd0)); // press in reset
        pending_items.push_back(make_item(OP_TICK, 16'd32768, 1'b0, 3'd0));  // capture zero
        pending_items.push_back(make_item(OP_TICK, 16'd0, 1'b0, 3'd0));      // leave reset
        pending_items.push_back(make_item(OP_SAMPLE, 16'd0, 1'b0, 3'd0));    // clamps at zero
        pending_items.push_back(make_item(OP_SAMPLE, 16'd40000, 1'b0, 3'd0)); // new peak
        pending_items.push_back(make_item(OP_SAMPLE, 16'd33000, 1'b0, 3'd0)); // below peak
        pending_items.push_back(make_item(OP_TICK, 16'hFFFF, 1'b0, 3'd0));
        pending_items.push_back(make_item(OP_SAMPLE, 16'hFFFF, 1'b0, 3'd0)); // over-range
        pending_items.push_back(make_item(OP_TICK, 16'd0, 1'b0, 3'd0));
        pending_items.push_back(make_item(OP_RANGE, 16'd0, 1'b0, 3'd7));     // to range one
        pending_items.push_back(make_item(OP_TICK, 16'd32768, 1'b1, 3'd0));
        pending_items.push_back(make_item(OP_TICK, 16'd32768, 1'b1, 3'd0));  // version shown
        pending_items.push_back(make_item(OP_BUTTON, 16'd0, 1'b0, 3'd0));    // accepted press
        pending_items.push_back(make_item(OP_TICK, 16'd0, 1'b0, 3'd0));      // release, capture
        pending_items.push_back(make_item(OP_TICK, 16'd0, 1'b0, 3'd0));
        pending_items.push_back(make_item(OP_RANGE, 16'd0, 1'b0, 3'd2));     // to range three
        pending_items.push_back(make_item(OP_RANGE, 16'd0, 1'b0, 3'd1));     // change in reset
        pending_items.push_back(make_item(OP_SPARE_LO, 16'hFFFF, 1'b1, 3'd7));
        pending_items.push_back(make_item(OP_SPARE_HI, 16'hFFFF, 1'b1, 3'd7));
        pending_items.push_back(make_item(OP_TICK, 16'd32768, 1'b0, 3'd0));
        pending_items.push_back(make_item(OP_TICK, 16'd32768, 1'b0, 3'd0));
        wait_quiet();

        // Reset values throughout; the long result hold-off lands in the next phase
        load_settings(GAIN_RST, 18'(OVER_LIM_RST), 18'(OVER_CODE_RST), BATT_THR_RST,
                      DISCHARGE_RST, SETTLE_RST, HOLD_RST, VERSION_RST);
        queue_phase(250, 1'b1);
        wait_quiet();

        // Top of every range: offsets saturate, nothing reaches the limit
        load_settings(16'hFFFF, 18'h3FFFF, 18'h3FFFF, 16'hFFFF, 8'd1, 8'd2, 8'd4, 8'hFF);
        queue_phase(250, 1'b1);
        wait_quiet();

        // Bottom of every range: zero gain, every sample over-range
        load_settings(16'h0000, 18'h00000, 18'h00000, 16'h0000, 8'd0, 8'd0, 8'd1, 8'h00);
        queue_phase(150, 1'b1);
        wait_quiet();

        // Longest waits: counters run up to saturation
        load_settings(16'd8192, 18'd3000, 18'd150000, 16'd30000, 8'hFF, 8'hFF, 8'hFF, 8'd42);
        queue_phase(350, 1'b1);
        wait_quiet();

        // Random settings, no idling on either side
        load_settings(16'($urandom), 18'($urandom_range(0, 4095)), 18'($urandom),
                      16'($urandom), 8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
                      8'($urandom_range(1, 12)), 8'($urandom));
        queue_phase(200, 1'b0);
        wait_quiet();

        @(negedge clk);
        if (expected_beats.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
            errors++;
        end
        $display("Covered %0d items under %0d register settings, %0d result beats checked",
                 items_taken, settings_run, beats_checked);
        $display("Among them %0d version and %0d over-range beats; %0d mismatches",
                 versions_seen, overs_seen, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
